### rtl/mad_pkg.sv
// Shared types and constants for the motion adaptive deinterlacer.
// No dependencies; every other rtl file except mad_checker imports this package.
`timescale 1ns / 1ps
package mad_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int STORED_ROWS = 4;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(STORED_ROWS);
  localparam int ROW_W       = 12;
  localparam int FW_W        = 12;
  localparam int PIX_W       = 8;
  localparam int TAPS        = 5;
  localparam int MID_TAP     = TAPS / 2;
  localparam int CFG_AW      = 1;
  localparam int CFG_DW      = 12;
  localparam int DEF_WIDTH   = 1920;
  // width of the column/width compare, must hold MAX_WIDTH and any register value
  localparam int CMP_W       = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
  // signed width for mirrored row math, holds 2 * 4096
  localparam int MIR_W       = ROW_W + 3;
  localparam int SV_W        = PIX_W + 3;

  typedef logic [PIX_W-1:0]       pix_t;
  typedef logic signed [SV_W-1:0] sval_t;

  typedef struct packed {
    pix_t prv;
    pix_t cur;
    pix_t nxt;
  } tri_t;

  typedef struct packed {
    logic              live;
    logic [SLOT_W-1:0] slot;
  } tap_sel_t;

  typedef struct packed {
    logic                  interp;
    logic                  last;
    logic                  par;
    tap_sel_t [TAPS-1:0]   sel;
  } item_ctl_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_FIELD_PARITY = 1'b0,
    REG_FRAME_WIDTH  = 1'b1
  } cfg_reg_e;

endpackage

### rtl/mad_linebuf.sv
// Line stores: one bank per stored row, each bank holds prev/cur/next pixels.
// Depends on mad_pkg.
`timescale 1ns / 1ps
module mad_linebuf (
  input  logic                                  clk_i,
  input  logic                                  rd_en_i,
  input  logic [mad_pkg::COL_W-1:0]             addr_i,
  input  logic                                  wr_en_i,
  input  logic [mad_pkg::SLOT_W-1:0]            wr_slot_i,
  input  mad_pkg::tri_t                         wr_data_i,
  output mad_pkg::tri_t [mad_pkg::STORED_ROWS-1:0] rd_data_o
);
  import mad_pkg::*;

  tri_t [STORED_ROWS-1:0] rd_q;

  for (genvar b = 0; b < STORED_ROWS; b++) begin : g_bank
    tri_t mem [MAX_WIDTH];

    // read returns the old word when the same row slot is written
    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q[b] <= mem[addr_i];
      end
      if (wr_en_i && (wr_slot_i == SLOT_W'(b))) begin
        mem[addr_i] <= wr_data_i;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/mad_ctrl.sv
// Raster counters, config registers and tap selection (edge mirroring).
// Depends on mad_pkg.
`timescale 1ns / 1ps
module mad_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mad_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [mad_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                          accept_i,
  input  logic                          mode_i,
  output logic                          emit_o,
  output mad_pkg::item_ctl_t            ctl_o,
  output logic [mad_pkg::COL_W-1:0]     col_o,
  output logic [mad_pkg::SLOT_W-1:0]    wr_slot_o
);
  import mad_pkg::*;

  logic             par_q;
  logic [FW_W-1:0]  width_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [1:0]       flush_q, flush_d;

  logic [CMP_W-1:0] w_eff, col_nx;
  logic             row_end;
  logic [1:0]       pend;
  logic             flush_act, last_row, step, live_en;
  logic [ROW_W-1:0] y;
  logic [ROW_W:0]   h;
  logic signed [MIR_W-1:0] hs;
  logic signed [MIR_W-1:0] ts [TAPS];
  logic [MIR_W-1:0]        ms [TAPS];

  always_comb begin
    if (width_q == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(width_q);
    end
    col_nx  = CMP_W'(col_q) + CMP_W'(1);
    row_end = (col_nx >= w_eff);
  end

  always_comb begin
    pend      = (row_q < ROW_W'(2)) ? row_q[1:0] : 2'd2;
    flush_act = (flush_q < pend);
    last_row  = ((3'(flush_q) + 3'd1) >= 3'(pend));
    if (!mode_i) begin
      // pixel word: output row trails by two, frame height so far is row + 1
      emit_o  = (row_q >= ROW_W'(2));
      y       = row_q - ROW_W'(2);
      h       = {1'b0, row_q} + (ROW_W+1)'(1);
      live_en = 1'b1;
      step    = 1'b1;
    end else begin
      emit_o  = flush_act;
      y       = row_q - ROW_W'(pend) + ROW_W'(flush_q);
      h       = {1'b0, row_q};
      live_en = 1'b0;
      step    = flush_act;
    end
  end

  // mirror rows y-2 .. y+2 into [0, h-1]; only h-5 .. h+1 can occur
  always_comb begin
    hs = $signed(MIR_W'(h));
    for (int k = 0; k < TAPS; k++) begin
      ts[k] = $signed(MIR_W'(y) + MIR_W'(k) - MIR_W'(2));
      if (h == (ROW_W+1)'(1)) begin
        ms[k] = '0;
      end else if (ts[k][MIR_W-1]) begin
        ms[k] = ~ts[k];
      end else if (ts[k] >= hs) begin
        ms[k] = hs + hs - ts[k] - MIR_W'(1);
      end else begin
        ms[k] = ts[k];
      end
      ctl_o.sel[k].live = live_en && (ms[k][ROW_W-1:0] == row_q);
      ctl_o.sel[k].slot = ms[k][SLOT_W-1:0];
    end
    ctl_o.interp = y[0] ^ par_q;
    ctl_o.last   = mode_i && row_end && last_row;
    ctl_o.par    = par_q;
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    flush_d = flush_q;
    if (step) begin
      col_d = row_end ? '0 : col_nx[COL_W-1:0];
      if (row_end) begin
        if (!mode_i) begin
          row_d = row_q + ROW_W'(1);
        end else if (last_row) begin
          row_d   = '0;
          flush_d = '0;
        end else begin
          flush_d = flush_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q   <= 1'b0;
      width_q <= FW_W'(DEF_WIDTH);
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_FIELD_PARITY: par_q   <= cfg_data_i[0];
          REG_FRAME_WIDTH:  width_q <= cfg_data_i[FW_W-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        col_q   <= col_d;
        row_q   <= row_d;
        flush_q <= flush_d;
      end
    end
  end

  assign col_o     = col_q;
  assign wr_slot_o = row_q[SLOT_W-1:0];

endmodule

### rtl/mad_filter.sv
// Per-pixel filter: gathers the five row taps and forms the clamped
// spatial/temporal estimate. Combinational. Depends on mad_pkg.
`timescale 1ns / 1ps
module mad_filter (
  input  mad_pkg::item_ctl_t                       ctl_i,
  input  mad_pkg::tri_t                            live_i,
  input  mad_pkg::tri_t [mad_pkg::STORED_ROWS-1:0] bank_i,
  output mad_pkg::pix_t                            pix_o,
  output logic                                     interp_o
);
  import mad_pkg::*;

  function automatic sval_t f_max(sval_t a, sval_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic sval_t f_min(sval_t a, sval_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sval_t f_absd(sval_t a, sval_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  tri_t  tap [TAPS];
  sval_t p [TAPS];
  sval_t c [TAPS];
  sval_t n [TAPS];
  sval_t spatial, d, t0, t1, t2, diff, b, f, lo, hi, bound;
  sval_t lim_lo, lim_hi, v0, v;

  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      tap[k] = ctl_i.sel[k].live ? live_i : bank_i[ctl_i.sel[k].slot];
      p[k]   = sval_t'({3'b000, tap[k].prv});
      c[k]   = sval_t'({3'b000, tap[k].cur});
      n[k]   = sval_t'({3'b000, tap[k].nxt});
    end
  end

  always_comb begin
    spatial = (c[1] >>> 1) + (c[3] >>> 1);
    d  = ctl_i.par ? (p[2] >>> 1) + (c[2] >>> 1) : (c[2] >>> 1) + (n[2] >>> 1);
    t0 = ctl_i.par ? (f_absd(p[2], c[2]) >>> 1) : (f_absd(c[2], n[2]) >>> 1);
    t1 = (f_absd(p[1], c[1]) >>> 1) + (f_absd(p[3], c[3]) >>> 1);
    t2 = (f_absd(n[1], c[1]) >>> 1) + (f_absd(n[3], c[3]) >>> 1);
    diff = f_max(f_max(t0, t1), t2);
    // halved two-frame sums two rows above and below
    b  = ctl_i.par ? (p[0] >>> 1) + (c[0] >>> 1) : (c[0] >>> 1) + (n[0] >>> 1);
    f  = ctl_i.par ? (p[4] >>> 1) + (c[4] >>> 1) : (c[4] >>> 1) + (n[4] >>> 1);
    lo = f_min(f_min(d - c[3], d - c[1]), f_max(b - c[1], f - c[3]));
    hi = f_max(f_max(d - c[3], d - c[1]), f_min(b - c[1], f - c[3]));
    bound  = f_max(f_max(diff, lo), -hi);
    lim_lo = d - bound;
    lim_hi = d + bound;
    v0 = (spatial < lim_lo) ? lim_lo : spatial;
    v  = (v0 > lim_hi) ? lim_hi : v0;
  end

  assign pix_o    = ctl_i.interp ? v[PIX_W-1:0] : tap[MID_TAP].cur;
  assign interp_o = ctl_i.interp;

endmodule

### rtl/motion_adaptive_deinterlacer_top.sv
// Motion adaptive deinterlacer, top level.
// Slave stream: one pixel triple (prev/cur/next frame) or one flush word per beat.
// Master stream: deinterlaced current frame, output row trails input by two rows.
// Config: write port, index 0 field_parity, index 1 frame_width (0 acts as 1,
//   widths above 2048 act as 2048). Write only while the block is idle.
// Pipeline: an accepted word is registered in the filter stage together with the
//   line store read, then in the output register. One word is accepted every
//   cycle unless the master side stalls.
// Words of the first two rows and surplus flush words give no output word.
// Flush words (tuser = 1) emit the final two rows, one pixel each; tlast marks
//   the last pixel of the frame, after which the row counter restarts.
// Reset clears counters and config to their defaults; line stores are not
//   cleared and need no clearing pass.
// Stall: when the master side holds tready low, the output register holds and
//   one more word may enter the filter stage before tready drops.
// Depends on mad_pkg, mad_ctrl, mad_linebuf, mad_filter.
`timescale 1ns / 1ps
module motion_adaptive_deinterlacer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [23:0]                s_axis_tdata_i,  // prev_pixel, cur_pixel, next_pixel
  input  logic                       s_axis_tuser_i,  // mode
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [7:0]                 m_axis_tdata_o,  // out_pixel
  output logic                       m_axis_tuser_o,  // interpolated
  output logic                       m_axis_tlast_o,  // frame_end
  input  logic                       cfg_we_i,
  input  logic [mad_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [mad_pkg::CFG_DW-1:0] cfg_data_i
);
  import mad_pkg::*;

  logic                   accept, emit, o_ready;
  item_ctl_t              ctl;
  logic [COL_W-1:0]       col;
  logic [SLOT_W-1:0]      wr_slot;
  tri_t                   in_tri;
  tri_t [STORED_ROWS-1:0] bank_rd;
  pix_t                   f_pix;
  logic                   f_interp;

  logic      s1_v_q;
  item_ctl_t s1_ctl_q;
  tri_t      s1_live_q;
  logic      o_v_q, o_interp_q, o_last_q;
  pix_t      o_pix_q;

  assign in_tri.prv = s_axis_tdata_i[PIX_W-1:0];
  assign in_tri.cur = s_axis_tdata_i[2*PIX_W-1:PIX_W];
  assign in_tri.nxt = s_axis_tdata_i[3*PIX_W-1:2*PIX_W];

  assign o_ready         = !o_v_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_v_q || o_ready;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  mad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .mode_i     (s_axis_tuser_i),
    .emit_o     (emit),
    .ctl_o      (ctl),
    .col_o      (col),
    .wr_slot_o  (wr_slot)
  );

  mad_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .addr_i    (col),
    .wr_en_i   (accept && !s_axis_tuser_i),
    .wr_slot_i (wr_slot),
    .wr_data_i (in_tri),
    .rd_data_o (bank_rd)
  );

  mad_filter u_filter (
    .ctl_i    (s1_ctl_q),
    .live_i   (s1_live_q),
    .bank_i   (bank_rd),
    .pix_o    (f_pix),
    .interp_o (f_interp)
  );

  // filter stage, loads together with the line store read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= emit;
    end else if (o_ready) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q  <= ctl;
      s1_live_q <= in_tri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_ready) begin
      o_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && s1_v_q) begin
      o_pix_q    <= f_pix;
      o_interp_q <= f_interp;
      o_last_q   <= s1_ctl_q.last;
    end
  end

  assign m_axis_tvalid_o = o_v_q;
  assign m_axis_tdata_o  = o_pix_q;
  assign m_axis_tuser_o  = o_interp_q;
  assign m_axis_tlast_o  = o_last_q;

endmodule

### rtl/mad_checker.sv
// Port-level checks for the deinterlacer top level, attached by bind.
// Depends on motion_adaptive_deinterlacer_top.
`timescale 1ns / 1ps
module mad_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [7:0]                 m_axis_tdata_o,
  input logic                       m_axis_tuser_o,
  input logic                       m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // every new output word comes from an earlier accepted input word
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("output word without matching input word");

endmodule

bind motion_adaptive_deinterlacer_top mad_checker u_mad_checker (.*);
